### rtl/assert_macros.svh
// Assertion macros used by the checker file.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, quiet while reset is low.
`define CHK_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

// Clocked assertion that also checks across reset.
`define CHK_ASSERT_NR(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

### rtl/rgbc_pkg.sv
// Package for the RGB convolution block: command codes, register indexes,
// field widths and channel masks. No dependencies.
`default_nettype none

package rgbc_pkg;

    localparam int CH_W   = 8;
    localparam int DIV_W  = 16;
    localparam int COEF_W = 16;
    localparam int NUM_CH = 3;
    localparam int PIX_W  = NUM_CH * CH_W;

    localparam logic [1:0] CMD_LOAD  = 2'd0;
    localparam logic [1:0] CMD_PIXEL = 2'd1;
    localparam logic [1:0] CMD_DRAIN = 2'd2;

    localparam logic [2:0] REG_WIDTH   = 3'd0;
    localparam logic [2:0] REG_HEIGHT  = 3'd1;
    localparam logic [2:0] REG_KSIZE   = 3'd2;
    localparam logic [2:0] REG_DIVISOR = 3'd3;
    localparam logic [2:0] REG_FORMAT  = 3'd4;

    localparam logic [10:0] RST_WIDTH   = 11'd1024;
    localparam logic [15:0] RST_HEIGHT  = 16'd1024;
    localparam logic [3:0]  RST_KSIZE   = 4'd3;
    localparam logic [15:0] RST_DIVISOR = 16'd1;

    localparam logic [CH_W-1:0] MASK_FULL = 8'hFF;
    localparam logic [CH_W-1:0] MASK_5    = 8'h1F;
    localparam logic [CH_W-1:0] MASK_6    = 8'h3F;

endpackage

`default_nettype wire

### rtl/rgb_convolution_2d.sv
// RGB 2-D convolution with zero padding, streaming over raster-order pixels.
// Input channel: i_in_valid / o_in_stall with cmd, coefficient and pixel fields.
// Output channel: o_out_valid / i_out_stall with filtered channels and frame flag.
// Configuration: i_cfg_valid / o_cfg_ready write port, index 0..4, always ready;
// write only while the block is idle.
// Flow: a load is taken in the idle state and leaves the block idle. A pixel or
// drain is accepted, then a window check returns to idle when no output is due;
// else one coefficient and one line memory read follow per tap, then the
// multiply-accumulate flush and the divider chain of SW cells (31 cells at the
// default kernel limit). The result lands in the output register at the edge
// that frees the input. One request is in work at a time.
// Reset clears positions and registers to their defaults; coefficient and line
// memories keep whatever they hold and must be written before use.
// A stalled result holds in the output register; the next request is accepted
// meanwhile, and its result waits at the divider launch until the register empties.
// Depends on rgbc_pkg and rgbc_div_cell.
`default_nettype none

module rgb_convolution_2d
    import rgbc_pkg::*;
#(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_KERNEL = 9
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_stall,
    input  wire logic [1:0]        i_cmd,
    input  wire logic [6:0]        i_coef_index,
    input  wire logic [COEF_W-1:0] i_coef_value,
    input  wire logic [CH_W-1:0]   i_red,
    input  wire logic [CH_W-1:0]   i_green,
    input  wire logic [CH_W-1:0]   i_blue,
    output logic                   o_out_valid,
    input  wire logic              i_out_stall,
    output logic [CH_W-1:0]        o_out_red,
    output logic [CH_W-1:0]        o_out_green,
    output logic [CH_W-1:0]        o_out_blue,
    output logic                   o_frame_last,
    input  wire logic              i_cfg_valid,
    output logic                   o_cfg_ready,
    input  wire logic [2:0]        i_cfg_index,
    input  wire logic [15:0]       i_cfg_data
);

    localparam int L     = MAX_KERNEL + 1;
    localparam int SLW   = $clog2(L);
    localparam int CW    = $clog2(MAX_WIDTH);
    localparam int WW    = $clog2(MAX_WIDTH + 1);
    localparam int XW    = CW + 2;
    localparam int YW    = 18;
    localparam int KW    = $clog2(MAX_KERNEL + 1);
    localparam int NCOEF = MAX_KERNEL * MAX_KERNEL;
    localparam int CAW   = (NCOEF > 1) ? $clog2(NCOEF) : 1;
    localparam int AW    = $clog2(L * MAX_WIDTH);
    localparam longint unsigned SUM_MAX = 64'd255 * 64'd65535 * NCOEF;
    localparam int SW    = $clog2(SUM_MAX + 1);
    localparam int PW    = CH_W + COEF_W;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_CHECK = 3'd1;
    localparam logic [2:0] S_TAPS  = 3'd2;
    localparam logic [2:0] S_FLUSH = 3'd3;
    localparam logic [2:0] S_DIV   = 3'd4;

    logic [2:0]        r_state;
    logic [10:0]       r_cfg_width;
    logic [15:0]       r_cfg_height;
    logic [3:0]        r_cfg_ksize;
    logic [DIV_W-1:0]  r_cfg_div;
    logic              r_cfg_fmt;

    logic [15:0]       r_in_row, r_out_row;
    logic [CW-1:0]     r_in_col, r_out_col;
    logic [SLW-1:0]    r_in_slot, r_out_slot;

    logic [KW-1:0]     r_tn, r_tm;
    logic signed [YW-1:0] r_ty;
    logic signed [XW-1:0] r_tx, r_tx0;
    logic [SLW-1:0]    r_tslot;
    logic [CAW-1:0]    r_caddr;

    logic              r_p1, r_p2;
    logic [PIX_W-1:0]  r_pix_q;
    logic [COEF_W-1:0] r_coef_q;
    logic [NUM_CH-1:0][PW-1:0] r_prod;
    logic [NUM_CH-1:0][SW-1:0] r_acc;

    logic              r_out_valid, r_out_last;
    logic [CH_W-1:0]   r_out_r, r_out_g, r_out_b;

    logic [PIX_W-1:0]  r_line_mem [L*MAX_WIDTH];
    logic [COEF_W-1:0] r_coef_mem [NCOEF];

    logic [WW-1:0]     w_ew;
    logic [15:0]       w_eh;
    logic [KW-1:0]     w_k, w_half, w_reach;
    logic              w_in_acc, w_ready, w_tap_ok, w_last_tap, w_launch, w_done;
    logic              w_new_frame, w_in_wrap, w_out_wrap;
    logic [15:0]       w_row_cur;
    logic [CW-1:0]     w_col_cur;
    logic [SLW-1:0]    w_slot_cur, w_slot_start;
    logic [SLW:0]      w_slot_tmp;
    logic [16:0]       w_nr;
    logic [WW:0]       w_nc;
    logic [AW-1:0]     w_waddr, w_raddr;
    logic [CH_W-1:0]   w_mask_rb, w_mask_g;
    logic [CH_W-1:0]   w_px [NUM_CH];

    logic              w_cv   [SW+1];
    logic [NUM_CH-1:0][DIV_W-1:0] w_crem [SW+1];
    logic [NUM_CH-1:0][SW-1:0]    w_cdvd [SW+1];
    logic [NUM_CH-1:0][CH_W-1:0]  w_cquo [SW+1];

    always_comb begin
        if (r_cfg_width == 11'd0) begin
            w_ew = WW'(1);
        end else if (32'(r_cfg_width) > MAX_WIDTH) begin
            w_ew = WW'(MAX_WIDTH);
        end else begin
            w_ew = WW'(r_cfg_width);
        end
        w_eh = (r_cfg_height == 16'd0) ? 16'd1 : r_cfg_height;
        if (r_cfg_ksize == 4'd0) begin
            w_k = KW'(1);
        end else if (32'(r_cfg_ksize) > MAX_KERNEL) begin
            w_k = KW'(MAX_KERNEL);
        end else begin
            w_k = KW'(r_cfg_ksize);
        end
        w_half  = w_k >> 1;
        w_reach = w_k - KW'(1) - w_half;
    end

    assign w_in_acc   = i_in_valid && !o_in_stall;
    assign o_in_stall = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;

    assign w_new_frame = (r_in_row >= w_eh);
    assign w_row_cur   = w_new_frame ? 16'd0 : r_in_row;
    assign w_col_cur   = w_new_frame ? '0 : r_in_col;
    assign w_slot_cur  = w_new_frame ? '0 : r_in_slot;
    assign w_in_wrap   = (WW'(w_col_cur) + WW'(1) >= w_ew);
    assign w_out_wrap  = (WW'(r_out_col) + WW'(1) >= w_ew);
    assign w_waddr     = AW'(w_slot_cur) * AW'(MAX_WIDTH) + AW'(w_col_cur);
    assign w_raddr     = AW'(r_tslot) * AW'(MAX_WIDTH) + AW'(r_tx[CW-1:0]);

    always_comb begin
        w_nr = 17'(r_out_row) + 17'(w_reach);
        if (w_nr > 17'(w_eh) - 17'd1) begin
            w_nr = 17'(w_eh) - 17'd1;
        end
        w_nc = (WW+1)'(r_out_col) + (WW+1)'(w_reach);
        if (w_nc > (WW+1)'(w_ew) - (WW+1)'(1)) begin
            w_nc = (WW+1)'(w_ew) - (WW+1)'(1);
        end
        w_ready = (r_out_row < w_eh) &&
                  ((17'(r_in_row) > w_nr) ||
                   ((17'(r_in_row) == w_nr) && ((WW+1)'(r_in_col) > w_nc)));
        w_slot_tmp = {1'b0, r_out_slot} + (SLW+1)'(L) - (SLW+1)'(w_half);
        if (w_slot_tmp >= (SLW+1)'(L)) begin
            w_slot_tmp = w_slot_tmp - (SLW+1)'(L);
        end
        w_slot_start = w_slot_tmp[SLW-1:0];
    end

    assign w_tap_ok = (r_ty >= 0) && (r_ty < $signed(YW'(w_eh))) &&
                      (r_tx >= 0) && (r_tx < $signed(XW'(w_ew)));
    assign w_last_tap = (r_tn == w_k - KW'(1)) && (r_tm == w_k - KW'(1));
    assign w_launch   = (r_state == S_FLUSH) && !r_p1 && !r_p2 && !r_out_valid;
    assign w_done     = (r_state == S_DIV) && w_cv[SW];

    always_ff @(posedge i_clk) begin
        if (w_in_acc && (i_cmd == CMD_PIXEL)) begin
            r_line_mem[w_waddr] <= {i_red, i_green, i_blue};
        end
        r_pix_q <= r_line_mem[w_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc && (i_cmd == CMD_LOAD) && (32'(i_coef_index) < NCOEF)) begin
            r_coef_mem[CAW'(i_coef_index)] <= i_coef_value;
        end
        r_coef_q <= r_coef_mem[r_caddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_width  <= RST_WIDTH;
            r_cfg_height <= RST_HEIGHT;
            r_cfg_ksize  <= RST_KSIZE;
            r_cfg_div    <= RST_DIVISOR;
            r_cfg_fmt    <= 1'b0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                REG_WIDTH:   r_cfg_width  <= i_cfg_data[10:0];
                REG_HEIGHT:  r_cfg_height <= i_cfg_data;
                REG_KSIZE:   r_cfg_ksize  <= i_cfg_data[3:0];
                REG_DIVISOR: r_cfg_div    <= i_cfg_data;
                REG_FORMAT:  r_cfg_fmt    <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_in_row   <= '0;
            r_in_col   <= '0;
            r_in_slot  <= '0;
            r_out_row  <= '0;
            r_out_col  <= '0;
            r_out_slot <= '0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (w_in_acc && (i_cmd == CMD_PIXEL)) begin
                        if (w_new_frame) begin
                            r_out_row  <= '0;
                            r_out_col  <= '0;
                            r_out_slot <= '0;
                        end
                        if (w_in_wrap) begin
                            r_in_col  <= '0;
                            r_in_row  <= w_row_cur + 16'd1;
                            r_in_slot <= (w_slot_cur == SLW'(L - 1)) ? '0
                                                                     : w_slot_cur + SLW'(1);
                        end else begin
                            r_in_col  <= w_col_cur + CW'(1);
                            r_in_row  <= w_row_cur;
                            r_in_slot <= w_slot_cur;
                        end
                        r_state <= S_CHECK;
                    end else if (w_in_acc && (i_cmd == CMD_DRAIN)) begin
                        r_state <= S_CHECK;
                    end
                end
                S_CHECK: begin
                    r_state <= w_ready ? S_TAPS : S_IDLE;
                end
                S_TAPS: begin
                    if (w_last_tap) begin
                        r_state <= S_FLUSH;
                    end
                end
                S_FLUSH: begin
                    if (w_launch) begin
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    if (w_done) begin
                        if (w_out_wrap) begin
                            r_out_col  <= '0;
                            r_out_row  <= r_out_row + 16'd1;
                            r_out_slot <= (r_out_slot == SLW'(L - 1)) ? '0
                                                                      : r_out_slot + SLW'(1);
                        end else begin
                            r_out_col <= r_out_col + CW'(1);
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_CHECK) begin
            r_tn    <= '0;
            r_tm    <= '0;
            r_ty    <= $signed(YW'(r_out_row)) - $signed(YW'(w_half));
            r_tx    <= $signed(XW'(r_out_col)) - $signed(XW'(w_half));
            r_tx0   <= $signed(XW'(r_out_col)) - $signed(XW'(w_half));
            r_tslot <= w_slot_start;
            r_caddr <= '0;
        end else if (r_state == S_TAPS) begin
            r_caddr <= r_caddr + CAW'(1);
            if (r_tm == w_k - KW'(1)) begin
                r_tm    <= '0;
                r_tn    <= r_tn + KW'(1);
                r_tx    <= r_tx0;
                r_ty    <= r_ty + YW'(1);
                r_tslot <= (r_tslot == SLW'(L - 1)) ? '0 : r_tslot + SLW'(1);
            end else begin
                r_tm <= r_tm + KW'(1);
                r_tx <= r_tx + XW'(1);
            end
        end
    end

    assign w_mask_rb = r_cfg_fmt ? MASK_5 : MASK_FULL;
    assign w_mask_g  = r_cfg_fmt ? MASK_6 : MASK_FULL;
    assign w_px[0]   = r_pix_q[23:16] & w_mask_rb;
    assign w_px[1]   = r_pix_q[15:8]  & w_mask_g;
    assign w_px[2]   = r_pix_q[7:0]   & w_mask_rb;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p1 <= 1'b0;
            r_p2 <= 1'b0;
        end else begin
            r_p1 <= (r_state == S_TAPS) && w_tap_ok;
            r_p2 <= r_p1;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int c = 0; c < NUM_CH; c++) begin
            r_prod[c] <= PW'(w_px[c]) * PW'(r_coef_q);
            if (r_state == S_CHECK) begin
                r_acc[c] <= '0;
            end else if (r_p2) begin
                r_acc[c] <= r_acc[c] + SW'(r_prod[c]);
            end
        end
    end

    assign w_cv[0]   = w_launch;
    assign w_crem[0] = '0;
    assign w_cdvd[0] = r_acc;
    assign w_cquo[0] = '0;

    for (genvar g = 0; g < SW; g++) begin : g_cell
        rgbc_div_cell #(
            .DW (SW)
        ) u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_valid   (w_cv[g]),
            .i_divisor (r_cfg_div),
            .i_rem     (w_crem[g]),
            .i_dvd     (w_cdvd[g]),
            .i_quo     (w_cquo[g]),
            .o_valid   (w_cv[g+1]),
            .o_rem     (w_crem[g+1]),
            .o_dvd     (w_cdvd[g+1]),
            .o_quo     (w_cquo[g+1])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_done) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_done) begin
            if (r_cfg_div == '0) begin
                r_out_r <= w_mask_rb;
                r_out_g <= w_mask_g;
                r_out_b <= w_mask_rb;
            end else begin
                r_out_r <= w_cquo[SW][0] & w_mask_rb;
                r_out_g <= w_cquo[SW][1] & w_mask_g;
                r_out_b <= w_cquo[SW][2] & w_mask_rb;
            end
            r_out_last <= (r_out_row == w_eh - 16'd1) &&
                          (WW'(r_out_col) >= w_ew - WW'(1));
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_out_red    = r_out_r;
    assign o_out_green  = r_out_g;
    assign o_out_blue   = r_out_b;
    assign o_frame_last = r_out_last;

endmodule

`default_nettype wire

### rtl/rgbc_div_cell.sv
// One restoring division step for three channels, registered.
// Depends on rgbc_pkg.
`default_nettype none

module rgbc_div_cell
    import rgbc_pkg::*;
#(
    parameter int DW = 31
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_valid,
    input  wire logic [DIV_W-1:0]                 i_divisor,
    input  wire logic [NUM_CH-1:0][DIV_W-1:0]     i_rem,
    input  wire logic [NUM_CH-1:0][DW-1:0]        i_dvd,
    input  wire logic [NUM_CH-1:0][CH_W-1:0]      i_quo,
    output logic                                  o_valid,
    output logic [NUM_CH-1:0][DIV_W-1:0]          o_rem,
    output logic [NUM_CH-1:0][DW-1:0]             o_dvd,
    output logic [NUM_CH-1:0][CH_W-1:0]           o_quo
);

    logic [NUM_CH-1:0][DIV_W-1:0] n_rem;
    logic [NUM_CH-1:0][DW-1:0]    n_dvd;
    logic [NUM_CH-1:0][CH_W-1:0]  n_quo;
    logic [DIV_W:0]               w_trial [NUM_CH];
    logic [DIV_W:0]               w_diff  [NUM_CH];
    logic                         w_ge    [NUM_CH];

    always_comb begin
        for (int c = 0; c < NUM_CH; c++) begin
            w_trial[c] = {i_rem[c], i_dvd[c][DW-1]};
            w_ge[c]    = w_trial[c] >= {1'b0, i_divisor};
            w_diff[c]  = w_trial[c] - {1'b0, i_divisor};
            n_rem[c]   = w_ge[c] ? w_diff[c][DIV_W-1:0] : w_trial[c][DIV_W-1:0];
            n_dvd[c]   = {i_dvd[c][DW-2:0], 1'b0};
            n_quo[c]   = {i_quo[c][CH_W-2:0], w_ge[c]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else begin
            o_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        o_rem <= n_rem;
        o_dvd <= n_dvd;
        o_quo <= n_quo;
    end

endmodule

`default_nettype wire

### rtl/rgbc_checker.sv
// Port-level checks for rgb_convolution_2d, attached by bind.
// Depends on rgbc_pkg and assert_macros.svh.
`default_nettype none

`include "assert_macros.svh"

module rgbc_checker
    import rgbc_pkg::*;
(
    input wire logic            i_clk,
    input wire logic            i_rst_n,
    input wire logic            i_in_valid,
    input wire logic            o_in_stall,
    input wire logic [1:0]      i_cmd,
    input wire logic            o_out_valid,
    input wire logic            i_out_stall,
    input wire logic [CH_W-1:0] o_out_red,
    input wire logic [CH_W-1:0] o_out_green,
    input wire logic [CH_W-1:0] o_out_blue,
    input wire logic            o_frame_last
);

    logic w_in_acc;

    assign w_in_acc = i_in_valid && !o_in_stall;

    `CHK_ASSERT_NR(a_reset_empty, i_clk, !i_rst_n |=> !o_out_valid, "result after reset")
    `CHK_ASSERT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_red) && $stable(o_out_green) && $stable(o_out_blue) && $stable(o_frame_last), "stalled result changed")
    `CHK_ASSERT(a_load_ready, i_clk, i_rst_n, w_in_acc && (i_cmd == CMD_LOAD) |=> !o_in_stall, "load request held input")
    `CHK_ASSERT(a_pixel_busy, i_clk, i_rst_n, w_in_acc && (i_cmd == CMD_PIXEL) |=> o_in_stall, "pixel request not held")
    `CHK_ASSERT(a_result_idle, i_clk, i_rst_n, $rose(o_out_valid) |-> !o_in_stall, "result while busy")

endmodule

bind rgb_convolution_2d rgbc_checker u_rgbc_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in_valid),
    .o_in_stall   (o_in_stall),
    .i_cmd        (i_cmd),
    .o_out_valid  (o_out_valid),
    .i_out_stall  (i_out_stall),
    .o_out_red    (o_out_red),
    .o_out_green  (o_out_green),
    .o_out_blue   (o_out_blue),
    .o_frame_last (o_frame_last)
);

`default_nettype wire

### sim/rgb_convolution_2d_tb.sv
// Self-checking testbench for rgb_convolution_2d: random-gap stimulus of coefficient loads,
// pixel frames and drains, checked against a built-in prediction of the filtered pixels.
// Depends on rgbc_pkg and the rgb_convolution_2d RTL.
`timescale 1ns / 100ps

module rgb_convolution_2d_tb;
    import rgbc_pkg::*;

    localparam int MAX_W     = 1024;
    localparam int MAX_K     = 9;
    localparam int ROWS      = MAX_K + 1;
    localparam int SETTLE    = 250;
    localparam int HOLD_CYC  = 1500;
    localparam int IDLE_MAX  = 20000;
    localparam int ITEM_GOAL = 1200;
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    typedef struct {
        logic [CH_W-1:0] r;
        logic [CH_W-1:0] g;
        logic [CH_W-1:0] b;
        logic            last;
    } t_out_pix;

    class t_conv_scoreboard;
        logic [10:0] width_reg;
        logic [15:0] height_reg;
        logic [3:0]  ksize_reg;
        logic [15:0] div_reg;
        logic        fmt_reg;
        logic [COEF_W-1:0] coefs[MAX_K*MAX_K];
        logic [PIX_W-1:0]  lines[ROWS][MAX_W];
        int unsigned in_row, in_col, out_row, out_col;
        t_out_pix pixel_q[$];
        int errors;
        int checked;

        function void reset_state();
            width_reg = RST_WIDTH;
            height_reg = RST_HEIGHT;
            ksize_reg = RST_KSIZE;
            div_reg = RST_DIVISOR;
            fmt_reg = 1'b0;
            in_row = 0; in_col = 0; out_row = 0; out_col = 0;
        endfunction

        function void init();
            reset_state();
            errors = 0; checked = 0;
        endfunction

        function int unsigned eff_w();
            int unsigned w;
            w = width_reg;
            if (w == 0) w = 1;
            if (w > MAX_W) w = MAX_W;
            return w;
        endfunction

        function int unsigned eff_h();
            return (height_reg == 0) ? 1 : height_reg;
        endfunction

        function int unsigned eff_k();
            int unsigned k;
            k = ksize_reg;
            if (k == 0) k = 1;
            if (k > MAX_K) k = MAX_K;
            return k;
        endfunction

        function void write_reg(logic [2:0] idx, logic [15:0] data);
            case (idx)
                REG_WIDTH:   width_reg = data[10:0];
                REG_HEIGHT:  height_reg = data;
                REG_KSIZE:   ksize_reg = data[3:0];
                REG_DIVISOR: div_reg = data;
                REG_FORMAT:  fmt_reg = data[0];
                default: ;
            endcase
        endfunction

        function int unsigned outputs_left();
            if (in_row < eff_h() || out_row >= eff_h()) return 0;
            return (eff_h() - out_row) * eff_w() - out_col;
        endfunction

        function void emit();
            int unsigned w, h, k, half, reach, nr, nc;
            int y, x;
            longint unsigned sr, sg, sb;
            logic [CH_W-1:0] mr, mg;
            logic [PIX_W-1:0] px;
            t_out_pix p;
            w = eff_w(); h = eff_h(); k = eff_k();
            half = k >> 1;
            reach = k - 1 - half;
            if (out_row >= h) return;
            nr = out_row + reach;
            if (nr > h - 1) nr = h - 1;
            nc = out_col + reach;
            if (nc > w - 1) nc = w - 1;
            if (!(in_row > nr || (in_row == nr && in_col > nc))) return;
            mr = fmt_reg ? MASK_5 : MASK_FULL;
            mg = fmt_reg ? MASK_6 : MASK_FULL;
            sr = 0; sg = 0; sb = 0;
            for (int n = 0; n < k; n++) begin
                y = int'(out_row) - int'(half) + n;
                if (y < 0 || y >= int'(h)) continue;
                for (int m = 0; m < k; m++) begin
                    x = int'(out_col) - int'(half) + m;
                    if (x < 0 || x >= int'(w)) continue;
                    px = lines[y % ROWS][x];
                    sr += longint'(px[23:16] & mr) * coefs[n*k+m];
                    sg += longint'(px[15:8] & mg) * coefs[n*k+m];
                    sb += longint'(px[7:0] & mr) * coefs[n*k+m];
                end
            end
            if (div_reg == 0) begin
                p.r = mr; p.g = mg; p.b = mr;
            end else begin
                p.r = CH_W'(sr / div_reg) & mr;
                p.g = CH_W'(sg / div_reg) & mg;
                p.b = CH_W'(sb / div_reg) & mr;
            end
            p.last = (out_row == h - 1 && out_col >= w - 1);
            if (out_col + 1 >= w) begin
                out_col = 0;
                out_row++;
            end else begin
                out_col++;
            end
            pixel_q.push_back(p);
        endfunction

        function void note_request(logic [1:0] cmd, logic [6:0] idx, logic [15:0] val,
                                   logic [7:0] r, logic [7:0] g, logic [7:0] b);
            if (cmd == CMD_LOAD) begin
                if (idx < MAX_K * MAX_K) coefs[idx] = val;
            end else if (cmd == CMD_PIXEL) begin
                if (in_row >= eff_h()) begin
                    in_row = 0; in_col = 0; out_row = 0; out_col = 0;
                end
                lines[in_row % ROWS][in_col] = {r, g, b};
                if (in_col + 1 >= eff_w()) begin
                    in_col = 0;
                    in_row++;
                    if (in_row >= eff_h()) in_row = eff_h();
                end else begin
                    in_col++;
                end
                emit();
            end else if (cmd == CMD_DRAIN) begin
                emit();
            end
        endfunction

        function void check_result(logic [7:0] r, logic [7:0] g, logic [7:0] b, logic last);
            t_out_pix e;
            if (pixel_q.size() == 0) begin
                $display("%0t: unexpected result r=%h g=%h b=%h last=%b", $time, r, g, b, last);
                errors++;
                return;
            end
            e = pixel_q.pop_front();
            checked++;
            if (r !== e.r) begin
                $display("%0t: red mismatch expected %h actual %h", $time, e.r, r);
                errors++;
            end
            if (g !== e.g) begin
                $display("%0t: green mismatch expected %h actual %h", $time, e.g, g);
                errors++;
            end
            if (b !== e.b) begin
                $display("%0t: blue mismatch expected %h actual %h", $time, e.b, b);
                errors++;
            end
            if (last !== e.last) begin
                $display("%0t: frame_last mismatch expected %b actual %b", $time, e.last, last);
                errors++;
            end
        endfunction
    endclass

    logic              i_clk;
    logic              i_rst_n;
    logic              i_in_valid;
    logic              o_in_stall;
    logic [1:0]        i_cmd;
    logic [6:0]        i_coef_index;
    logic [COEF_W-1:0] i_coef_value;
    logic [CH_W-1:0]   i_red, i_green, i_blue;
    logic              o_out_valid;
    logic              i_out_stall;
    logic [CH_W-1:0]   o_out_red, o_out_green, o_out_blue;
    logic              o_frame_last;
    logic              i_cfg_valid;
    logic              o_cfg_ready;
    logic [2:0]        i_cfg_index;
    logic [15:0]       i_cfg_data;

    t_conv_scoreboard sb;
    int n_items;
    int n_phases;
    int idle_cycles;
    bit hold_req;

    rgb_convolution_2d DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_stall(o_in_stall),
        .i_cmd(i_cmd), .i_coef_index(i_coef_index), .i_coef_value(i_coef_value),
        .i_red(i_red), .i_green(i_green), .i_blue(i_blue),
        .o_out_valid(o_out_valid), .i_out_stall(i_out_stall),
        .o_out_red(o_out_red), .o_out_green(o_out_green), .o_out_blue(o_out_blue),
        .o_frame_last(o_frame_last),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic int gap_len();
        int p;
        p = $urandom_range(0, 99);
        if (p < 65) return 0;
        if (p < 95) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    task automatic send_request(logic [1:0] cmd, logic [6:0] idx, logic [15:0] val,
                                logic [7:0] r, logic [7:0] g, logic [7:0] b);
        int g_len;
        g_len = gap_len();
        if (g_len > 0) begin
            @(negedge i_clk) i_in_valid <= 1'b0;
            repeat (g_len - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        i_in_valid <= 1'b1;
        i_cmd <= cmd;
        i_coef_index <= idx;
        i_coef_value <= val;
        i_red <= r;
        i_green <= g;
        i_blue <= b;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        sb.note_request(cmd, idx, val, r, g, b);
        n_items++;
    endtask

    task automatic send_pixel(logic [23:0] rgb);
        send_request(CMD_PIXEL, 7'($urandom), 16'($urandom), rgb[23:16], rgb[15:8], rgb[7:0]);
    endtask

    task automatic send_noise();
        case ($urandom_range(0, 2))
            0: send_request(CMD_UNUSED, 7'($urandom), 16'($urandom), 8'($urandom),
                            8'($urandom), 8'($urandom));
            1: send_request(CMD_DRAIN, 7'($urandom), 16'($urandom), 8'($urandom),
                            8'($urandom), 8'($urandom));
            default: send_request(CMD_LOAD, 7'($urandom_range(81, 127)), 16'($urandom),
                                  8'($urandom), 8'($urandom), 8'($urandom));
        endcase
    endtask

    task automatic settle();
        @(negedge i_clk) i_in_valid <= 1'b0;
        while (sb.pixel_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic apply_reset();
        @(negedge i_clk) i_rst_n <= 1'b0;
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;
        sb.reset_state();
    endtask

    task automatic write_reg(logic [2:0] idx, logic [15:0] data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        sb.write_reg(idx, data);
        @(negedge i_clk) i_cfg_valid <= 1'b0;
    endtask

    function automatic logic [15:0] rand_coef();
        int p;
        p = $urandom_range(0, 99);
        if (p < 5) return 16'hFFFF;
        if (p < 12) return 16'd0;
        return 16'($urandom_range(0, 300));
    endfunction

    task automatic run_phase(int w, int h, int k, int dv, int fmt, int frames);
        int kk, npix, eh;
        settle();
        eh = (h == 0) ? 1 : h;
        if ((sb.in_row != 0 || sb.in_col != 0) && sb.in_row < eh) apply_reset();
        write_reg(REG_WIDTH, 16'(w));
        write_reg(REG_HEIGHT, 16'(h));
        write_reg(REG_KSIZE, 16'(k));
        write_reg(REG_DIVISOR, 16'(dv));
        write_reg(REG_FORMAT, 16'(fmt));
        n_phases++;
        kk = sb.eff_k();
        for (int i = 0; i < kk * kk; i++) begin
            send_request(CMD_LOAD, 7'(i), rand_coef(), 8'($urandom), 8'($urandom),
                         8'($urandom));
            if ($urandom_range(0, 99) < 3) send_noise();
        end
        npix = sb.eff_w() * sb.eff_h();
        for (int f = 0; f < frames; f++) begin
            for (int i = 0; i < npix; i++) begin
                send_pixel(24'($urandom));
                if ($urandom_range(0, 99) < 3) send_noise();
            end
            if (f == frames - 1 || $urandom_range(0, 99) < 80) begin
                for (int d = sb.outputs_left() + $urandom_range(0, 2); d > 0; d--)
                    send_request(CMD_DRAIN, 7'($urandom), 16'($urandom), 8'($urandom),
                                 8'($urandom), 8'($urandom));
            end
        end
    endtask

    task automatic run_directed();
        settle();
        write_reg(REG_WIDTH, 16'd0);
        write_reg(REG_HEIGHT, 16'hFFFF);
        write_reg(REG_KSIZE, 16'd0);
        write_reg(REG_DIVISOR, 16'd0);
        write_reg(REG_FORMAT, 16'd1);
        send_request(CMD_LOAD, 7'd0, 16'hFFFF, 8'h00, 8'h00, 8'h00);
        send_request(CMD_LOAD, 7'd127, 16'h1234, 8'hFF, 8'hFF, 8'hFF);
        send_request(CMD_LOAD, 7'd81, 16'hFFFF, 8'h00, 8'h00, 8'h00);
        send_request(CMD_UNUSED, 7'h7F, 16'hFFFF, 8'hFF, 8'hFF, 8'hFF);
        send_request(CMD_DRAIN, 7'h00, 16'h0000, 8'h00, 8'h00, 8'h00);
        send_pixel(24'h000000);
        send_pixel(24'hFFFFFF);
        settle();
        write_reg(REG_DIVISOR, 16'd1);
        send_request(CMD_LOAD, 7'd0, 16'd1, 8'h00, 8'h00, 8'h00);
        send_pixel(24'hFFFFFF);
        send_pixel(24'hAA55C3);
        send_pixel(24'h3F1F20);
        settle();
        write_reg(REG_DIVISOR, 16'hFFFF);
        write_reg(REG_FORMAT, 16'd0);
        send_request(CMD_LOAD, 7'd0, 16'hFFFF, 8'h00, 8'h00, 8'h00);
        send_pixel(24'hFFFFFF);
        send_pixel(24'h7F8001);
        settle();
        write_reg(REG_DIVISOR, 16'd1);
        send_pixel(24'hFFFFFF);
        send_pixel(24'h123456);
        settle();
        write_reg(REG_HEIGHT, 16'(sb.in_row));
        send_request(CMD_DRAIN, 7'h00, 16'h0000, 8'h00, 8'h00, 8'h00);
    endtask

    task automatic run_random();
        int w, h, k, dv, p;
        bit big_done;
        big_done = 0;
        while (n_items < ITEM_GOAL) begin
            if (!big_done && n_items > 100) begin
                big_done = 1;
                settle();
                hold_req = 1'b1;
                run_phase(2047, 1, 1, $urandom_range(1, 300), $urandom_range(0, 1), 1);
                continue;
            end
            p = $urandom_range(0, 99);
            w = (p < 85) ? $urandom_range(1, 10) : $urandom_range(11, 40);
            h = $urandom_range(1, 6);
            p = $urandom_range(0, 99);
            if (p < 60) k = $urandom_range(1, 3);
            else if (p < 85) k = $urandom_range(4, 8);
            else if (p < 95) k = $urandom_range(9, 15);
            else k = 0;
            if (k >= 6) begin
                w = $urandom_range(1, 6);
                h = $urandom_range(1, 4);
            end
            p = $urandom_range(0, 99);
            if (p < 8) dv = 0;
            else if (p < 16) dv = 1;
            else if (p < 22) dv = 16'hFFFF;
            else dv = $urandom_range(2, 3000);
            run_phase(w, h, k, dv, $urandom_range(0, 1), $urandom_range(1, 3));
        end
    endtask

    initial begin
        sb = new();
        sb.init();
        n_items = 0;
        n_phases = 0;
        hold_req = 1'b0;
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_cmd = CMD_LOAD;
        i_coef_index = '0;
        i_coef_value = '0;
        i_red = '0;
        i_green = '0;
        i_blue = '0;
        i_out_stall = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = REG_WIDTH;
        i_cfg_data = '0;
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;
        run_directed();
        run_random();
        settle();
        if (sb.pixel_q.size() != 0) sb.errors++;
        $display("Covered %0d requests over %0d settings, %0d results checked.",
                 n_items, n_phases, sb.checked);
        if (sb.errors == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    initial begin
        @(posedge i_rst_n);
        forever begin
            if (hold_req) begin
                @(negedge i_clk) i_out_stall <= 1'b1;
                repeat (HOLD_CYC) @(negedge i_clk);
                hold_req = 1'b0;
            end else if ($urandom_range(0, 99) < 30) begin
                @(negedge i_clk) i_out_stall <= 1'b0;
                repeat ($urandom_range(0, 60)) @(negedge i_clk);
            end else begin
                @(negedge i_clk) i_out_stall <= (gap_len() > 0);
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall)
            sb.check_result(o_out_red, o_out_green, o_out_blue, o_frame_last);
    end

    initial begin
        idle_cycles = 0;
        forever begin
            @(posedge i_clk);
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)
                    || (i_cfg_valid && o_cfg_ready) || !i_rst_n)
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_MAX) begin
                $display("%0t: timeout, no handshake for %0d cycles", $time, IDLE_MAX);
                $display("Regression FAIL");
                $finish;
            end
        end
    end

endmodule
